>>> rtl/uvpr_pkg.sv
package uvpr_pkg;

    localparam int IN_W     = 24;
    localparam int EDGE_W   = 19;
    localparam int DIM_W    = 15;
    localparam int FLAG_W   = 4;
    localparam int CFG_IDX_W = 2;

    localparam int IN_DATA_W  = 4 * IN_W;
    localparam int OUT_USED_W = 4 * EDGE_W + 4 * DIM_W + FLAG_W;
    localparam int OUT_DATA_W = ((OUT_USED_W + 7) / 8) * 8;

    localparam int OUT_REQ_LEFT_LSB    = 0;
    localparam int OUT_REQ_TOP_LSB     = OUT_REQ_LEFT_LSB + EDGE_W;
    localparam int OUT_REQ_WIDTH_LSB   = OUT_REQ_TOP_LSB + EDGE_W;
    localparam int OUT_REQ_HEIGHT_LSB  = OUT_REQ_WIDTH_LSB + EDGE_W;
    localparam int OUT_CLIP_LEFT_LSB   = OUT_REQ_HEIGHT_LSB + EDGE_W;
    localparam int OUT_CLIP_TOP_LSB    = OUT_CLIP_LEFT_LSB + DIM_W;
    localparam int OUT_CLIP_WIDTH_LSB  = OUT_CLIP_TOP_LSB + DIM_W;
    localparam int OUT_CLIP_HEIGHT_LSB = OUT_CLIP_WIDTH_LSB + DIM_W;
    localparam int OUT_FLAGS_LSB       = OUT_CLIP_HEIGHT_LSB + DIM_W;

    localparam int FLAG_SWAP_U  = 0;
    localparam int FLAG_SWAP_V  = 1;
    localparam int FLAG_CLAMPED = 2;
    localparam int FLAG_EMPTY   = 3;

    localparam logic [DIM_W-1:0] ATLAS_DIM_RESET = DIM_W'(1024);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ATLAS_WIDTH  = 2'd0,
        CFG_ATLAS_HEIGHT = 2'd1,
        CFG_ORIGIN_MODE  = 2'd2,
        CFG_ROUND_MODE   = 2'd3
    } t_cfg_idx;

    typedef enum logic [1:0] {
        ROUND_EXPAND   = 2'd0,
        ROUND_NEAREST  = 2'd1,
        ROUND_CONTRACT = 2'd2
    } t_round_mode;

    localparam logic ORIGIN_TOP_LEFT    = 1'b0;
    localparam logic ORIGIN_BOTTOM_LEFT = 1'b1;

endpackage

>>> rtl/uv_rect_to_pixel_rect_unit.sv
// Converts a UV rectangle of four signed fixed-point coordinates into a pixel rectangle
// of the atlas: the requested edges and size, the same rectangle clamped to the atlas,
// and warning flags, with an error result while either atlas size is zero. The block is
// a five-stage pipeline (input register, ordering and v flip, the scaling multipliers,
// rounding, clamping into the output register); it takes one rectangle every clock while
// the output is not stalled, and each result is presented on the output once it has passed
// through all five registers in that order.
// Backpressure stalls only the full stages, so empty stages still take new transfers.
// Configuration is to be written only while the pipeline is empty.
module uv_rect_to_pixel_rect_unit #(
    parameter int COORD_FRAC_BITS = 20,
    parameter int MAX_ATLAS_DIM   = 16384
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [uvpr_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [uvpr_pkg::DIM_W-1:0]         i_cfg_data,
    input  logic                               i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    // u_low, u_high, v_low, v_high
    input  logic [uvpr_pkg::IN_DATA_W-1:0]     i_s_axis_tdata,
    output logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    // req_left, req_top, req_width, req_height, clip_left, clip_top, clip_width,
    // clip_height, warning_flags, zero fill
    output logic [uvpr_pkg::OUT_DATA_W-1:0]    o_m_axis_tdata,
    // bad_atlas
    output logic                               o_m_axis_tuser
);
    import uvpr_pkg::*;

    localparam int F  = COORD_FRAC_BITS;
    localparam int CW = ((IN_W > F + 1) ? IN_W : F + 1) + 1;
    localparam int PW = CW + DIM_W + 1;
    localparam int EW = PW + 1 - F;
    localparam logic [DIM_W-1:0] SAT_DIM =
        (MAX_ATLAS_DIM > (2 ** DIM_W) - 1) ? {DIM_W{1'b1}} : DIM_W'(MAX_ATLAS_DIM);
    localparam logic signed [CW-1:0] ONE_C = CW'(64'sd1 <<< F);
    localparam logic [PW:0] ONE_M1  = (PW + 1)'((64'd1 << F) - 64'd1);
    localparam logic [PW:0] HALF    = (PW + 1)'(64'd1 << (F - 1));
    localparam logic [PW:0] HALF_M1 = (PW + 1)'((64'd1 << (F - 1)) - 64'd1);

    logic [DIM_W-1:0] r_atlas_width;
    logic [DIM_W-1:0] r_atlas_height;
    logic             r_origin_mode;
    logic [1:0]       r_round_mode;
    logic [DIM_W-1:0] n_dim;

    logic adv1, adv2, adv3, adv4, adv5;

    logic                    r_s1_vld;
    logic signed [IN_W-1:0]  r_s1_ul, r_s1_uh, r_s1_vl, r_s1_vh;
    logic                    r_s2_vld;
    logic signed [CW-1:0]    r_s2_ul, r_s2_uh, r_s2_vt, r_s2_vb;
    logic [1:0]              r_s2_swap;
    logic                    r_s3_vld;
    logic signed [PW-1:0]    r_s3_pl, r_s3_pr, r_s3_pt, r_s3_pb;
    logic [1:0]              r_s3_swap;
    logic                    r_s4_vld;
    logic signed [EW-1:0]    r_s4_left, r_s4_right, r_s4_top, r_s4_bottom;
    logic [1:0]              r_s4_swap;
    logic                    r_s5_vld;
    logic [OUT_DATA_W-1:0]   r_s5_data;
    logic                    r_s5_user;

    logic                    swap_u, swap_v;
    logic signed [CW-1:0]    n2_ul, n2_uh, n2_vl, n2_vh, n2_vt, n2_vb;
    logic signed [DIM_W:0]   w_s, h_s;
    logic [DIM_W-1:0]        cl, cr, ct, cb, cw, ch;
    logic signed [DIM_W:0]   cw_d, ch_d;
    logic signed [EW:0]      rw_d, rh_d;
    logic [EDGE_W-1:0]       rw, rh;
    logic [FLAG_W-1:0]       flags;
    logic                    bad;
    logic [OUT_DATA_W-1:0]   n5_data;

    function automatic logic signed [EW-1:0] f_round(input logic signed [PW-1:0] p,
                                                     input logic is_min);
        logic [PW:0]        bias;
        logic signed [PW:0] s;
        case (r_round_mode)
            ROUND_NEAREST:  bias = p[PW-1] ? HALF_M1 : HALF;
            ROUND_CONTRACT: bias = is_min ? ONE_M1 : '0;
            default:        bias = is_min ? '0 : ONE_M1;
        endcase
        s = (PW + 1)'(p) + $signed(bias);
        return s[PW:F];
    endfunction

    function automatic logic [DIM_W-1:0] f_clamp(input logic signed [EW-1:0] e,
                                                 input logic [DIM_W-1:0] lim);
        logic signed [EW-1:0] lim_s;
        lim_s = EW'(lim);
        if (e[EW-1]) begin
            return '0;
        end else if (e > lim_s) begin
            return lim;
        end
        return e[DIM_W-1:0];
    endfunction

    // Configuration registers.
    assign n_dim = (i_cfg_data > SAT_DIM) ? SAT_DIM : i_cfg_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_atlas_width  <= ATLAS_DIM_RESET;
            r_atlas_height <= ATLAS_DIM_RESET;
            r_origin_mode  <= ORIGIN_TOP_LEFT;
            r_round_mode   <= ROUND_EXPAND;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_ATLAS_WIDTH:  r_atlas_width  <= n_dim;
                CFG_ATLAS_HEIGHT: r_atlas_height <= n_dim;
                CFG_ORIGIN_MODE:  r_origin_mode  <= i_cfg_data[0];
                CFG_ROUND_MODE:   r_round_mode   <= i_cfg_data[1:0];
                default: ;
            endcase
        end
    end

    // Pipeline advance: a stage moves when it is empty or its successor moves.
    assign adv5 = !r_s5_vld || i_m_axis_tready;
    assign adv4 = !r_s4_vld || adv5;
    assign adv3 = !r_s3_vld || adv4;
    assign adv2 = !r_s2_vld || adv3;
    assign adv1 = !r_s1_vld || adv2;
    assign o_s_axis_tready = adv1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
            r_s3_vld <= 1'b0;
            r_s4_vld <= 1'b0;
            r_s5_vld <= 1'b0;
        end else begin
            if (adv1) begin
                r_s1_vld <= i_s_axis_tvalid;
            end
            if (adv2) begin
                r_s2_vld <= r_s1_vld;
            end
            if (adv3) begin
                r_s3_vld <= r_s2_vld;
            end
            if (adv4) begin
                r_s4_vld <= r_s3_vld;
            end
            if (adv5) begin
                r_s5_vld <= r_s4_vld;
            end
        end
    end

    // Stage 2: put each pair in order and flip v for a bottom-left origin.
    always_comb begin
        swap_u = r_s1_ul > r_s1_uh;
        swap_v = r_s1_vl > r_s1_vh;
        n2_ul  = swap_u ? CW'(r_s1_uh) : CW'(r_s1_ul);
        n2_uh  = swap_u ? CW'(r_s1_ul) : CW'(r_s1_uh);
        n2_vl  = swap_v ? CW'(r_s1_vh) : CW'(r_s1_vl);
        n2_vh  = swap_v ? CW'(r_s1_vl) : CW'(r_s1_vh);
        if (r_origin_mode == ORIGIN_BOTTOM_LEFT) begin
            n2_vt = ONE_C - n2_vh;
            n2_vb = ONE_C - n2_vl;
        end else begin
            n2_vt = n2_vl;
            n2_vb = n2_vh;
        end
    end

    assign w_s = $signed({1'b0, r_atlas_width});
    assign h_s = $signed({1'b0, r_atlas_height});

    // Stage 5: clamp to the atlas, build the flags and zero the fields while an atlas size is zero.
    always_comb begin
        bad   = (r_atlas_width == '0) || (r_atlas_height == '0);
        cl    = f_clamp(r_s4_left, r_atlas_width);
        cr    = f_clamp(r_s4_right, r_atlas_width);
        ct    = f_clamp(r_s4_top, r_atlas_height);
        cb    = f_clamp(r_s4_bottom, r_atlas_height);
        cw_d  = $signed({1'b0, cr}) - $signed({1'b0, cl});
        ch_d  = $signed({1'b0, cb}) - $signed({1'b0, ct});
        cw    = cw_d[DIM_W] ? '0 : cw_d[DIM_W-1:0];
        ch    = ch_d[DIM_W] ? '0 : ch_d[DIM_W-1:0];
        rw_d  = (EW + 1)'(r_s4_right) - (EW + 1)'(r_s4_left);
        rh_d  = (EW + 1)'(r_s4_bottom) - (EW + 1)'(r_s4_top);
        rw    = rw_d[EW] ? '0 : rw_d[EDGE_W-1:0];
        rh    = rh_d[EW] ? '0 : rh_d[EDGE_W-1:0];
        flags = '0;
        flags[FLAG_SWAP_U]  = r_s4_swap[0];
        flags[FLAG_SWAP_V]  = r_s4_swap[1];
        flags[FLAG_CLAMPED] = (EW'(cl) != r_s4_left) || (EW'(cr) != r_s4_right)
                           || (EW'(ct) != r_s4_top) || (EW'(cb) != r_s4_bottom);
        flags[FLAG_EMPTY]   = (cw == '0) || (ch == '0);
        n5_data = '0;
        if (!bad) begin
            n5_data[OUT_USED_W-1:0] = {flags, ch, cw, ct, cl, rh, rw,
                                       r_s4_top[EDGE_W-1:0], r_s4_left[EDGE_W-1:0]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv1) begin
            r_s1_ul <= i_s_axis_tdata[IN_W-1:0];
            r_s1_uh <= i_s_axis_tdata[2*IN_W-1:IN_W];
            r_s1_vl <= i_s_axis_tdata[3*IN_W-1:2*IN_W];
            r_s1_vh <= i_s_axis_tdata[4*IN_W-1:3*IN_W];
        end
        if (adv2) begin
            r_s2_ul   <= n2_ul;
            r_s2_uh   <= n2_uh;
            r_s2_vt   <= n2_vt;
            r_s2_vb   <= n2_vb;
            r_s2_swap <= {swap_v, swap_u};
        end
        if (adv3) begin
            r_s3_pl   <= r_s2_ul * w_s;
            r_s3_pr   <= r_s2_uh * w_s;
            r_s3_pt   <= r_s2_vt * h_s;
            r_s3_pb   <= r_s2_vb * h_s;
            r_s3_swap <= r_s2_swap;
        end
        if (adv4) begin
            r_s4_left   <= f_round(r_s3_pl, 1'b1);
            r_s4_right  <= f_round(r_s3_pr, 1'b0);
            r_s4_top    <= f_round(r_s3_pt, 1'b1);
            r_s4_bottom <= f_round(r_s3_pb, 1'b0);
            r_s4_swap   <= r_s3_swap;
        end
        if (adv5) begin
            r_s5_data <= n5_data;
            r_s5_user <= bad;
        end
    end

    assign o_m_axis_tvalid = r_s5_vld;
    assign o_m_axis_tdata  = r_s5_data;
    assign o_m_axis_tuser  = r_s5_user;

endmodule

>>> rtl/uvpr_checker.sv
module uvpr_checker (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    input  logic [uvpr_pkg::OUT_DATA_W-1:0]    o_m_axis_tdata,
    input  logic                               o_m_axis_tuser
);
    import uvpr_pkg::*;

    logic [EDGE_W-1:0] req_left, req_width;
    logic [DIM_W-1:0]  clip_left, clip_width, clip_height;
    logic [FLAG_W-1:0] flags;
    logic              good;

    assign req_left    = o_m_axis_tdata[OUT_REQ_LEFT_LSB +: EDGE_W];
    assign req_width   = o_m_axis_tdata[OUT_REQ_WIDTH_LSB +: EDGE_W];
    assign clip_left   = o_m_axis_tdata[OUT_CLIP_LEFT_LSB +: DIM_W];
    assign clip_width  = o_m_axis_tdata[OUT_CLIP_WIDTH_LSB +: DIM_W];
    assign clip_height = o_m_axis_tdata[OUT_CLIP_HEIGHT_LSB +: DIM_W];
    assign flags       = o_m_axis_tdata[OUT_FLAGS_LSB +: FLAG_W];
    assign good        = o_m_axis_tvalid && !o_m_axis_tuser;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid
            && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser))
        else $error("Stalled result transfer changed.");

    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser |-> o_m_axis_tdata == '0)
        else $error("Error result carries nonzero fields.");

    a_empty_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        good |-> flags[FLAG_EMPTY] == (clip_width == '0 || clip_height == '0))
        else $error("Empty-crop flag disagrees with the clamped size.");

    a_clip_narrower: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        good |-> EDGE_W'(clip_width) <= req_width)
        else $error("Clamped width exceeds requested width.");

    a_unclamped_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        good && !flags[FLAG_CLAMPED] |->
            !req_left[EDGE_W-1] && EDGE_W'(clip_left) == req_left)
        else $error("Unclamped result has a clamped left edge that differs.");

endmodule

bind uv_rect_to_pixel_rect_unit uvpr_checker u_uvpr_checker (.*);

>>> dv/uv_rect_pixel_checker.sv
`timescale 1ns / 100ps

module uv_rect_pixel_checker #(
    parameter int FRAC_BITS = 20,
    parameter int MAX_DIM   = 16384
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [uvpr_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [uvpr_pkg::DIM_W-1:0]      i_cfg_data,
    input  logic                            i_s_axis_tvalid,
    input  logic                            i_s_axis_tready,
    // u_low, u_high, v_low, v_high
    input  logic [uvpr_pkg::IN_DATA_W-1:0]  i_s_axis_tdata,
    input  logic                            i_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    // req_left, req_top, req_width, req_height, clip_left, clip_top, clip_width,
    // clip_height, warning_flags, zero fill
    input  logic [uvpr_pkg::OUT_DATA_W-1:0] i_m_axis_tdata,
    // bad_atlas
    input  logic                            i_m_axis_tuser,
    output int                              o_failures,
    output int                              o_pending,
    output int                              o_results
);
    import uvpr_pkg::*;

    typedef struct packed {
        logic [EDGE_W-1:0] left;
        logic [EDGE_W-1:0] top;
        logic [EDGE_W-1:0] width;
        logic [EDGE_W-1:0] height;
        logic [DIM_W-1:0]  c_left;
        logic [DIM_W-1:0]  c_top;
        logic [DIM_W-1:0]  c_width;
        logic [DIM_W-1:0]  c_height;
        logic [FLAG_W-1:0] flags;
        logic              bad;
    } t_pixel_rect;

    t_pixel_rect       rects_due[$];
    logic [DIM_W-1:0]  atlas_w;
    logic [DIM_W-1:0]  atlas_h;
    logic              origin_sel;
    logic [1:0]        rounding;
    int                fail_count;
    int                result_count;

    function automatic longint pixel_edge(longint p, bit min_edge);
        longint fl;
        longint ce;
        longint mag;
        longint near_mag;
        fl       = p >>> FRAC_BITS;
        ce       = -((-p) >>> FRAC_BITS);
        mag      = (p < 0) ? -p : p;
        near_mag = (mag + (longint'(1) << (FRAC_BITS - 1))) >>> FRAC_BITS;
        if (rounding == ROUND_NEAREST) begin
            return (p < 0) ? -near_mag : near_mag;
        end
        if (rounding == ROUND_CONTRACT) begin
            return min_edge ? ce : fl;
        end
        return min_edge ? fl : ce;
    endfunction

    function automatic longint to_atlas(longint v, longint lim);
        if (v < 0) begin
            return 0;
        end
        return (v > lim) ? lim : v;
    endfunction

    function automatic t_pixel_rect predict_pixel_rect(logic [IN_DATA_W-1:0] d);
        t_pixel_rect r;
        longint ul, uh, vl, vh, sw, w, h, y0, y1;
        longint left, right, top, bottom;
        longint cl, cr, ct, cb, rw, rh, cw, ch;
        r = '0;
        w = longint'(atlas_w);
        h = longint'(atlas_h);
        if (w == 0 || h == 0) begin
            r.bad = 1'b1;
            return r;
        end
        ul = longint'($signed(d[0*IN_W +: IN_W]));
        uh = longint'($signed(d[1*IN_W +: IN_W]));
        vl = longint'($signed(d[2*IN_W +: IN_W]));
        vh = longint'($signed(d[3*IN_W +: IN_W]));
        if (ul > uh) begin
            sw = ul;
            ul = uh;
            uh = sw;
            r.flags[FLAG_SWAP_U] = 1'b1;
        end
        if (vl > vh) begin
            sw = vl;
            vl = vh;
            vh = sw;
            r.flags[FLAG_SWAP_V] = 1'b1;
        end
        if (origin_sel == ORIGIN_BOTTOM_LEFT) begin
            y0 = (longint'(1) << FRAC_BITS) - vh;
            y1 = (longint'(1) << FRAC_BITS) - vl;
        end else begin
            y0 = vl;
            y1 = vh;
        end
        left   = pixel_edge(ul * w, 1'b1);
        right  = pixel_edge(uh * w, 1'b0);
        top    = pixel_edge(y0 * h, 1'b1);
        bottom = pixel_edge(y1 * h, 1'b0);
        rw = (right > left) ? right - left : 0;
        rh = (bottom > top) ? bottom - top : 0;
        cl = to_atlas(left, w);
        cr = to_atlas(right, w);
        ct = to_atlas(top, h);
        cb = to_atlas(bottom, h);
        cw = (cr > cl) ? cr - cl : 0;
        ch = (cb > ct) ? cb - ct : 0;
        if (cl != left || cr != right || ct != top || cb != bottom) begin
            r.flags[FLAG_CLAMPED] = 1'b1;
        end
        if (cw == 0 || ch == 0) begin
            r.flags[FLAG_EMPTY] = 1'b1;
        end
        r.left     = left[EDGE_W-1:0];
        r.top      = top[EDGE_W-1:0];
        r.width    = rw[EDGE_W-1:0];
        r.height   = rh[EDGE_W-1:0];
        r.c_left   = cl[DIM_W-1:0];
        r.c_top    = ct[DIM_W-1:0];
        r.c_width  = cw[DIM_W-1:0];
        r.c_height = ch[DIM_W-1:0];
        return r;
    endfunction

    function automatic int field_diff(string name, logic [EDGE_W-1:0] want,
                                      logic [EDGE_W-1:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
            return 1;
        end
        return 0;
    endfunction

    always @(posedge i_clk) begin
        t_pixel_rect want;
        t_pixel_rect got;
        if (!i_rst_n) begin
            atlas_w    = ATLAS_DIM_RESET;
            atlas_h    = ATLAS_DIM_RESET;
            origin_sel = ORIGIN_TOP_LEFT;
            rounding   = ROUND_EXPAND;
            rects_due.delete();
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_ATLAS_WIDTH: begin
                        atlas_w = (i_cfg_data > MAX_DIM) ? DIM_W'(MAX_DIM) : i_cfg_data;
                    end
                    CFG_ATLAS_HEIGHT: begin
                        atlas_h = (i_cfg_data > MAX_DIM) ? DIM_W'(MAX_DIM) : i_cfg_data;
                    end
                    CFG_ORIGIN_MODE: begin
                        origin_sel = i_cfg_data[0];
                    end
                    CFG_ROUND_MODE: begin
                        rounding = i_cfg_data[1:0];
                    end
                    default: begin
                    end
                endcase
            end
            if (i_s_axis_tvalid && i_s_axis_tready) begin
                rects_due.insert(rects_due.size(), predict_pixel_rect(i_s_axis_tdata));
            end
            if (i_m_axis_tvalid && i_m_axis_tready) begin
                result_count++;
                got.left     = i_m_axis_tdata[OUT_REQ_LEFT_LSB +: EDGE_W];
                got.top      = i_m_axis_tdata[OUT_REQ_TOP_LSB +: EDGE_W];
                got.width    = i_m_axis_tdata[OUT_REQ_WIDTH_LSB +: EDGE_W];
                got.height   = i_m_axis_tdata[OUT_REQ_HEIGHT_LSB +: EDGE_W];
                got.c_left   = i_m_axis_tdata[OUT_CLIP_LEFT_LSB +: DIM_W];
                got.c_top    = i_m_axis_tdata[OUT_CLIP_TOP_LSB +: DIM_W];
                got.c_width  = i_m_axis_tdata[OUT_CLIP_WIDTH_LSB +: DIM_W];
                got.c_height = i_m_axis_tdata[OUT_CLIP_HEIGHT_LSB +: DIM_W];
                got.flags    = i_m_axis_tdata[OUT_FLAGS_LSB +: FLAG_W];
                got.bad      = i_m_axis_tuser;
                if (rects_due.size() == 0) begin
                    fail_count++;
                    $display("%0t: result with no rectangle pending, expected none actual %h",
                             $time, i_m_axis_tdata);
                end else begin
                    want = rects_due.pop_front();
                    fail_count += field_diff("req_left", want.left, got.left)
                                + field_diff("req_top", want.top, got.top)
                                + field_diff("req_width", want.width, got.width)
                                + field_diff("req_height", want.height, got.height)
                                + field_diff("clip_left", EDGE_W'(want.c_left),
                                             EDGE_W'(got.c_left))
                                + field_diff("clip_top", EDGE_W'(want.c_top),
                                             EDGE_W'(got.c_top))
                                + field_diff("clip_width", EDGE_W'(want.c_width),
                                             EDGE_W'(got.c_width))
                                + field_diff("clip_height", EDGE_W'(want.c_height),
                                             EDGE_W'(got.c_height))
                                + field_diff("warning_flags", EDGE_W'(want.flags),
                                             EDGE_W'(got.flags))
                                + field_diff("bad_atlas", EDGE_W'(want.bad),
                                             EDGE_W'(got.bad));
                end
            end
        end
        o_pending  <= rects_due.size();
        o_failures <= fail_count;
        o_results  <= result_count;
    end

endmodule

>>> dv/uv_rect_to_pixel_rect_unit_tb.sv
`timescale 1ns / 100ps

module uv_rect_to_pixel_rect_unit_tb;
    import uvpr_pkg::*;

    localparam int FRAC_BITS   = 20;
    localparam int MAX_DIM     = 16384;
    localparam int STALL_LIMIT = 2000;
    localparam int HOLD_CYCLES = 400;
    localparam int ROUND_UNUSED = 3;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [DIM_W-1:0]      i_cfg_data = '0;
    logic                  i_s_axis_tvalid = 1'b0;
    logic                  o_s_axis_tready;
    // u_low, u_high, v_low, v_high
    logic [IN_DATA_W-1:0]  i_s_axis_tdata = '0;
    logic                  o_m_axis_tvalid;
    logic                  i_m_axis_tready = 1'b0;
    // req_left, req_top, req_width, req_height, clip_left, clip_top, clip_width,
    // clip_height, warning_flags, zero fill
    logic [OUT_DATA_W-1:0] o_m_axis_tdata;
    // bad_atlas
    logic                  o_m_axis_tuser;

    int chk_failures;
    int chk_pending;
    int chk_results;
    int rects_sent = 0;
    int cur_w = 1024;
    int cur_h = 1024;
    bit steady = 1'b0;
    bit hold_req = 1'b0;

    always #1 i_clk = ~i_clk;

    uv_rect_to_pixel_rect_unit #(
        .COORD_FRAC_BITS(FRAC_BITS),
        .MAX_ATLAS_DIM  (MAX_DIM)
    ) uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_s_axis_tvalid(i_s_axis_tvalid),
        .o_s_axis_tready(o_s_axis_tready),
        .i_s_axis_tdata (i_s_axis_tdata),
        .o_m_axis_tvalid(o_m_axis_tvalid),
        .i_m_axis_tready(i_m_axis_tready),
        .o_m_axis_tdata (o_m_axis_tdata),
        .o_m_axis_tuser (o_m_axis_tuser)
    );

    uv_rect_pixel_checker #(
        .FRAC_BITS(FRAC_BITS),
        .MAX_DIM  (MAX_DIM)
    ) u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_s_axis_tvalid(i_s_axis_tvalid),
        .i_s_axis_tready(o_s_axis_tready),
        .i_s_axis_tdata (i_s_axis_tdata),
        .i_m_axis_tvalid(o_m_axis_tvalid),
        .i_m_axis_tready(i_m_axis_tready),
        .i_m_axis_tdata (o_m_axis_tdata),
        .i_m_axis_tuser (o_m_axis_tuser),
        .o_failures     (chk_failures),
        .o_pending      (chk_pending),
        .o_results      (chk_results)
    );

    function automatic logic [IN_W-1:0] pick_coord(int dim);
        int     sel;
        longint pix;
        longint c;
        longint bump;
        sel = $urandom_range(0, 99);
        if (sel < 15) begin
            return IN_W'($urandom());
        end
        if (dim < 1) begin
            dim = 1;
        end
        if (sel < 35) begin
            pix  = longint'($urandom_range(0, dim));
            bump = $urandom_range(0, 1) ? (longint'(1) << (FRAC_BITS - 1)) : 0;
            c = ((pix << FRAC_BITS) + bump) / dim + int'($urandom_range(0, 2)) - 1;
            return IN_W'(c);
        end
        c = longint'($urandom_range(0, 5 << (FRAC_BITS - 2))) - (longint'(1) << (FRAC_BITS - 2));
        return IN_W'(c);
    endfunction

    task automatic make_pair(input int dim, output logic [IN_W-1:0] lo,
                             output logic [IN_W-1:0] hi);
        logic [IN_W-1:0] x;
        logic [IN_W-1:0] y;
        int              pick;
        x = pick_coord(dim);
        y = pick_coord(dim);
        pick = $urandom_range(0, 99);
        if (pick < 4) begin
            y = x;
        end
        if (pick < 85 && $signed(x) > $signed(y)) begin
            lo = y;
            hi = x;
        end else begin
            lo = x;
            hi = y;
        end
    endtask

    task automatic offer_rect(input logic [IN_W-1:0] ul, input logic [IN_W-1:0] uh,
                              input logic [IN_W-1:0] vl, input logic [IN_W-1:0] vh);
        steady = (rects_sent >= 600 && rects_sent < 900);
        if (rects_sent == 1300) begin
            hold_req = 1'b1;
        end
        if (!steady && $urandom_range(0, 99) < 20) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {vh, vl, uh, ul};
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        rects_sent++;
    endtask

    task automatic offer_random_rect();
        logic [IN_W-1:0] ul, uh, vl, vh;
        make_pair(cur_w, ul, uh);
        make_pair(cur_h, vl, vh);
        offer_rect(ul, uh, vl, vh);
    endtask

    task automatic drain_pipeline();
        i_s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (chk_pending != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic run_phase(input int w, input int h, input int org, input int rnd, input int n);
        int k;
        drain_pipeline();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_ATLAS_WIDTH;
        i_cfg_data <= DIM_W'(w);
        @(posedge i_clk);
        i_cfg_idx  <= CFG_ATLAS_HEIGHT;
        i_cfg_data <= DIM_W'(h);
        @(posedge i_clk);
        i_cfg_idx  <= CFG_ORIGIN_MODE;
        i_cfg_data <= DIM_W'(org);
        @(posedge i_clk);
        i_cfg_idx  <= CFG_ROUND_MODE;
        i_cfg_data <= DIM_W'(rnd);
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        cur_w = (w > MAX_DIM) ? MAX_DIM : w;
        cur_h = (h > MAX_DIM) ? MAX_DIM : h;
        for (k = 0; k < n; k++) begin
            offer_random_rect();
        end
    endtask

    initial begin
        int hold_left;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                i_m_axis_tready <= 1'b0;
                hold_left = HOLD_CYCLES;
                while (hold_left > 0) begin
                    @(posedge i_clk);
                    hold_left--;
                end
                hold_req = 1'b0;
            end else begin
                i_m_axis_tready <= steady || ($urandom_range(0, 99) >= 17);
            end
        end
    end

    initial begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((i_s_axis_tvalid && o_s_axis_tready)
                    || (o_m_axis_tvalid && i_m_axis_tready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
        $display("Regression FAIL");
        $finish;
    end

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Corner rectangles under the reset settings.
        offer_rect(24'h000000, 24'h000000, 24'h000000, 24'h000000);
        offer_rect(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF);
        offer_rect(24'h800000, 24'h800000, 24'h800000, 24'h800000);
        offer_rect(24'h800000, 24'h7FFFFF, 24'h800000, 24'h7FFFFF);
        offer_rect(24'h7FFFFF, 24'h800000, 24'h7FFFFF, 24'h800000);
        offer_rect(24'h000000, 24'h100000, 24'h000000, 24'h100000);
        offer_rect(24'h100000, 24'h000000, 24'h000000, 24'h100000);
        offer_rect(24'h000000, 24'h100000, 24'h100000, 24'h000000);
        offer_rect(24'h040000, 24'h040000, 24'h080000, 24'h080000);
        offer_rect(24'h000200, 24'h0FFE00, 24'h000200, 24'h0FFE00);
        offer_rect(24'hFFFE00, 24'h000001, 24'hFFFFFF, 24'h0001FF);
        offer_rect(24'h555555, 24'hAAAAAA, 24'hAAAAAA, 24'h555555);
        offer_rect(24'h100007, 24'h1FFFFF, 24'hF00000, 24'h055555);
        offer_rect(24'hFFFFFF, 24'h000001, 24'h7FFFFF, 24'h800001);

        run_phase(1, 1, ORIGIN_BOTTOM_LEFT, ROUND_NEAREST, 240);
        run_phase(MAX_DIM, MAX_DIM, ORIGIN_TOP_LEFT, ROUND_CONTRACT, 240);
        run_phase(32767, 300, ORIGIN_BOTTOM_LEFT, ROUND_UNUSED, 240);
        run_phase(0, 512, ORIGIN_TOP_LEFT, ROUND_EXPAND, 30);
        run_phase(640, 0, ORIGIN_BOTTOM_LEFT, ROUND_NEAREST, 30);
        run_phase(777, MAX_DIM - 1, ORIGIN_BOTTOM_LEFT, ROUND_CONTRACT, 240);
        run_phase($urandom_range(1, MAX_DIM), $urandom_range(1, MAX_DIM), $urandom_range(0, 1),
                  $urandom_range(0, 3), 240);
        run_phase(1024, 2048, ORIGIN_TOP_LEFT, ROUND_NEAREST, 240);
        run_phase(MAX_DIM, 1, ORIGIN_BOTTOM_LEFT, ROUND_EXPAND, 240);
        run_phase(3, 5, ORIGIN_TOP_LEFT, ROUND_CONTRACT, 240);
        drain_pipeline();

        $display("Sent %0d rectangles and checked %0d results over ten atlas settings,",
                 rects_sent, chk_results);
        $display("with zero and oversized atlas sizes, both origins and every rounding code.");
        if (chk_failures == 0 && chk_pending == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
